// ===== rtl/core/bsil_pkg.sv =====
package bsil_pkg;

    // Field widths fixed by the interface
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int CMD_W  = 4;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 4'd0,
        CMD_PUSH_FRONT = 4'd1,
        CMD_INSERT     = 4'd2,
        CMD_READ       = 4'd3,
        CMD_WRITE      = 4'd4,
        CMD_FRONT      = 4'd5,
        CMD_BACK       = 4'd6,
        CMD_CLEAR      = 4'd7,
        CMD_QUERY      = 4'd8
    } cmd_t;

    // Per-cell update control
    typedef struct packed {
        logic load;        // take the new value
        logic take_lower;  // take the lower neighbor's value (shift up)
    } cell_ctrl_t;

endpackage

// ===== rtl/core/bsil_cell.sv =====
module bsil_cell (
    input  logic                                clk,
    input  bsil_pkg::cell_ctrl_t                ctrl,
    input  logic signed [bsil_pkg::DATA_W-1:0]  new_value,
    input  logic signed [bsil_pkg::DATA_W-1:0]  lower_value,
    output logic signed [bsil_pkg::DATA_W-1:0]  value
);

    logic signed [bsil_pkg::DATA_W-1:0] value_reg;
    logic signed [bsil_pkg::DATA_W-1:0] value_next;

    // Shift from the neighbor wins over a local load
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.take_lower)
        begin
            value_next = lower_value;
        end
        else if (ctrl.load)
        begin
            value_next = new_value;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== rtl/core/bounded_shift_insert_list.sv =====
// A result is registered and appears in the cycle after its command is accepted, strobed by done.
// Throughput: one command per cycle; busy stays low and every shift is done at once
// because each entry lives in its own cell of a row that moves in parallel.
// The receiver cannot stall; each result is valid for the single cycle done is high.
// Reset: entry count clears to zero and capacity_reg returns to 16; entry cells
// are not reset and are only read below the count.
module bounded_shift_insert_list #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [bsil_pkg::CMD_W-1:0]          command,
    input  logic [bsil_pkg::POS_W-1:0]          position,
    input  logic signed [bsil_pkg::DATA_W-1:0]  value,
    // result channel
    output logic                                done,
    output logic signed [bsil_pkg::DATA_W-1:0]  read_data,
    output logic [4:0]                          entry_count,
    output logic                                is_empty,
    output logic                                accepted,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bsil_pkg::CAP_W-1:0]          cfg_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = (CW > bsil_pkg::CAP_W) ? CW : bsil_pkg::CAP_W;

    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic [bsil_pkg::CAP_W-1:0]     capacity_reg;

    logic                           done_reg;
    logic signed [bsil_pkg::DATA_W-1:0] read_data_reg;
    logic [4:0]                     entry_count_reg;
    logic                           is_empty_reg;
    logic                           accepted_reg;

    logic                           take;
    logic [CMPW-1:0]                count_ext;
    logic [CMPW-1:0]                pos_ext;
    logic [CMPW-1:0]                cap_ext;
    logic [CMPW-1:0]                cap_eff;
    logic                           room;
    logic                           do_insert;
    logic                           do_write;
    logic                           do_read;
    logic                           ok;
    logic [CMPW-1:0]                tgt;
    logic [CMPW-1:0]                rd_idx;
    logic signed [bsil_pkg::DATA_W-1:0] rd_value;

    logic [DEPTH-1:0]               load_vec;
    logic [DEPTH-1:0]               shift_vec;
    logic signed [bsil_pkg::DATA_W-1:0] cell_value [DEPTH];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign take      = start && !busy;

    // Effective capacity is the smaller of the register and the built depth
    assign count_ext = CMPW'(count_reg);
    assign pos_ext   = CMPW'(position);
    assign cap_ext   = CMPW'(capacity_reg);
    assign cap_eff   = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
    assign room      = count_ext < cap_eff;

    // Command decode
    always_comb
    begin
        do_insert  = 1'b0;
        do_write   = 1'b0;
        do_read    = 1'b0;
        ok         = 1'b0;
        tgt        = pos_ext;
        rd_idx     = pos_ext;
        count_next = count_reg;
        unique case (command)
            bsil_pkg::CMD_PUSH_BACK:
            begin
                tgt       = count_ext;
                do_insert = room;
            end
            bsil_pkg::CMD_PUSH_FRONT:
            begin
                tgt       = '0;
                do_insert = room;
            end
            bsil_pkg::CMD_INSERT:
            begin
                do_insert = room && (pos_ext <= count_ext);
            end
            bsil_pkg::CMD_READ:
            begin
                do_read = pos_ext < count_ext;
            end
            bsil_pkg::CMD_WRITE:
            begin
                do_write = pos_ext < count_ext;
                ok       = do_write;
            end
            bsil_pkg::CMD_FRONT:
            begin
                rd_idx  = '0;
                do_read = count_reg != '0;
            end
            bsil_pkg::CMD_BACK:
            begin
                rd_idx  = count_ext - CMPW'(1);
                do_read = count_reg != '0;
            end
            bsil_pkg::CMD_CLEAR:
            begin
                count_next = '0;
                ok         = 1'b1;
            end
            bsil_pkg::CMD_QUERY:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        if (do_insert)
        begin
            count_next = count_reg + CW'(1);
            ok         = 1'b1;
        end
        if (do_read)
        begin
            ok = 1'b1;
        end
    end

    // Per-cell controls: load at the target, shift cells above it up through the entry count
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            load_vec[i]  = take && (do_insert || do_write) && (tgt == CMPW'(i));
            shift_vec[i] = take && do_insert && (CMPW'(i) > tgt) && (CMPW'(i) <= count_ext);
        end
    end

    // Row of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        bsil_pkg::cell_ctrl_t ctrl;
        logic signed [bsil_pkg::DATA_W-1:0] lower;

        assign ctrl.load       = load_vec[g];
        assign ctrl.take_lower = shift_vec[g];
        if (g == 0)
        begin : g_first
            assign lower = value;
        end
        else
        begin : g_rest
            assign lower = cell_value[g-1];
        end

        bsil_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_value   (value),
            .lower_value (lower),
            .value       (cell_value[g])
        );
    end

    // Read port into the row
    assign rd_value = do_read ? cell_value[rd_idx[AW-1:0]] : '0;

    // Count and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= bsil_pkg::CAP_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= take;
            if (take)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            read_data_reg   <= rd_value;
            entry_count_reg <= 5'(count_next);
            is_empty_reg    <= count_next == '0;
            accepted_reg    <= ok;
        end
    end

    assign done        = done_reg;
    assign read_data   = read_data_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign accepted    = accepted_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CMPW'(DEPTH))
        else $error("entry count above depth");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> done)
        else $error("no result after accepted command");

    a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        done && !accepted |-> count_reg == $past(count_reg))
        else $error("refused command changed the count");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(load_vec))
        else $error("more than one cell loaded");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        take && command == bsil_pkg::CMD_CLEAR |=> count_reg == '0 && is_empty)
        else $error("clear left entries");
`endif

endmodule

// ===== tb/sv/list_result_checker.sv =====
`timescale 1ns / 1ps

module list_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [bsil_pkg::CMD_W-1:0]          command,
    input  logic [bsil_pkg::POS_W-1:0]          position,
    input  logic signed [bsil_pkg::DATA_W-1:0]  value,
    input  logic                                done,
    input  logic signed [bsil_pkg::DATA_W-1:0]  read_data,
    input  logic [4:0]                          entry_count,
    input  logic                                is_empty,
    input  logic                                accepted,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [bsil_pkg::CAP_W-1:0]          cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  granted_count
);
    import bsil_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [4:0]               count;
        logic                     empty;
        logic                     ok;
    } list_result_t;

    // Shadow copy of the list and its capacity register
    logic signed [DATA_W-1:0] list_mem [DEPTH];
    int                       n_used;
    int                       cap_limit;

    list_result_t expected_results [$];
    list_result_t want;
    list_result_t got;
    int           mismatches;
    int           granted;
    int           result_idx;

    // Move entries at pos and above up one slot, then place val at pos
    task automatic shift_in(input int pos, input logic signed [DATA_W-1:0] val);
        int i;
        begin
            for (i = n_used; i > pos; i--)
                list_mem[i] = list_mem[i-1];
            list_mem[pos] = val;
            n_used++;
        end
    endtask

    // Apply one command to the shadow list and work out its result
    task automatic predict_command(
        input  logic [CMD_W-1:0]         cmd,
        input  logic [POS_W-1:0]         pos,
        input  logic signed [DATA_W-1:0] val,
        output list_result_t             res
    );
        int  usable;
        logic room;
        begin
            res    = '0;
            usable = (cap_limit < DEPTH) ? cap_limit : DEPTH;
            room   = (n_used < usable);
            case (cmd)
                CMD_PUSH_BACK:
                    if (room)
                    begin
                        shift_in(n_used, val);
                        res.ok = 1'b1;
                    end
                CMD_PUSH_FRONT:
                    if (room)
                    begin
                        shift_in(0, val);
                        res.ok = 1'b1;
                    end
                CMD_INSERT:
                    if (room && int'(pos) <= n_used)
                    begin
                        shift_in(int'(pos), val);
                        res.ok = 1'b1;
                    end
                CMD_READ:
                    if (int'(pos) < n_used)
                    begin
                        res.data = list_mem[int'(pos)];
                        res.ok   = 1'b1;
                    end
                CMD_WRITE:
                    if (int'(pos) < n_used)
                    begin
                        list_mem[int'(pos)] = val;
                        res.ok              = 1'b1;
                    end
                CMD_FRONT:
                    if (n_used > 0)
                    begin
                        res.data = list_mem[0];
                        res.ok   = 1'b1;
                    end
                CMD_BACK:
                    if (n_used > 0)
                    begin
                        res.data = list_mem[n_used-1];
                        res.ok   = 1'b1;
                    end
                CMD_CLEAR:
                begin
                    n_used = 0;
                    res.ok = 1'b1;
                end
                CMD_QUERY:
                    res.ok = 1'b1;
                default: ;
            endcase
            res.count = 5'(n_used);
            res.empty = (n_used == 0);
        end
    endtask

    // Watch command, config and result channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            n_used        = 0;
            cap_limit     = int'(CAP_RESET);
            mismatches    = 0;
            granted       = 0;
            result_idx    = 0;
            fail_count    <= 0;
            pending       <= 0;
            granted_count <= 0;
        end
        else
        begin
            // accepted command: predict before checking
            if (start && !busy)
            begin
                predict_command(command, position, value, want);
                expected_results.push_back(want);
            end

            // capacity register write
            if (cfg_valid && cfg_ready)
                cap_limit = int'(cfg_data);

            // result transaction
            if (done)
            begin
                got.data  = read_data;
                got.count = entry_count;
                got.empty = is_empty;
                got.ok    = accepted;
                if (got.ok === 1'b1)
                    granted++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no command outstanding",
                                 result_idx);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.data !== want.data || got.count !== want.count ||
                        got.empty !== want.empty || got.ok !== want.ok)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d: expected data %0d count %0d empty %0b acc %0b",
                                     result_idx, want.data, want.count, want.empty,
                                     want.ok);
                            $display("    got data %0d count %0d empty %0b acc %0b",
                                     got.data, got.count, got.empty, got.ok);
                        end
                    end
                end
                result_idx++;
            end

            fail_count    <= mismatches;
            pending       <= expected_results.size();
            granted_count <= granted;
        end
    end

endmodule

// ===== tb/sv/tb_bounded_shift_insert_list.sv =====
`timescale 1ns / 1ps

module tb_bounded_shift_insert_list;
    import bsil_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int IDLE_LIMIT   = 1000;
    localparam int PHASE_ITEMS  = 97;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [CMD_W-1:0] CMD_TOP = {CMD_W{1'b1}};

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [CMD_W-1:0]          command;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
    logic                      done;
    logic signed [DATA_W-1:0]  read_data;
    logic [4:0]                entry_count;
    logic                      is_empty;
    logic                      accepted;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CAP_W-1:0]          cfg_data;

    int fail_count;
    int pending;
    int granted_count;
    int issued;
    int cfg_writes;
    int idle_cycles;
    bit burst;

    logic [CAP_W-1:0] phase_caps [7] = '{5'd31, 5'd3, 5'd0, 5'd1, 5'd16, 5'd9, 5'd15};

    bounded_shift_insert_list #(.DEPTH(LIST_DEPTH)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .position    (position),
        .value       (value),
        .done        (done),
        .read_data   (read_data),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .accepted    (accepted),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    list_result_checker #(.DEPTH(LIST_DEPTH)) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .position      (position),
        .value         (value),
        .done          (done),
        .read_data     (read_data),
        .entry_count   (entry_count),
        .is_empty      (is_empty),
        .accepted      (accepted),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .granted_count (granted_count)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: stop when no transaction of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (burst || r < 55)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            else
                return $urandom_range(8, 30);
        end
    endfunction

    // Present one command and hold it until it is taken
    task automatic issue(
        input logic [CMD_W-1:0]         cmd,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] val
    );
        int gap;
        begin
            start    <= 1'b1;
            command  <= cmd;
            position <= pos;
            value    <= val;
            do @(posedge clk); while (busy);
            issued++;
            gap = pick_gap();
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop issuing and let every outstanding result come back
    task automatic settle();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        begin
            settle();
            cfg_valid <= 1'b1;
            cfg_data  <= cap;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            cfg_writes++;
        end
    endtask

    // Weighted command mix: enough pushes and inserts to fill the list often
    task automatic random_command();
        int r;
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        begin
            r = $urandom_range(0, 99);
            if (r < 16)      cmd = CMD_PUSH_BACK;
            else if (r < 28) cmd = CMD_PUSH_FRONT;
            else if (r < 44) cmd = CMD_INSERT;
            else if (r < 58) cmd = CMD_READ;
            else if (r < 70) cmd = CMD_WRITE;
            else if (r < 77) cmd = CMD_FRONT;
            else if (r < 84) cmd = CMD_BACK;
            else if (r < 87) cmd = CMD_CLEAR;
            else if (r < 93) cmd = CMD_QUERY;
            else             cmd = CMD_W'($urandom_range(int'(CMD_QUERY) + 1, int'(CMD_TOP)));

            if ($urandom_range(0, 9) == 0)
                pos = POS_W'($urandom_range(0, 31));
            else
                pos = POS_W'($urandom_range(0, LIST_DEPTH));

            r = $urandom_range(0, 9);
            if (r == 0)      val = {1'b1, {(DATA_W-1){1'b0}}};
            else if (r == 1) val = {1'b0, {(DATA_W-1){1'b1}}};
            else             val = $urandom();

            issue(cmd, pos, val);
        end
    endtask

    initial
    begin
        int p;
        int k;
        logic [CAP_W-1:0] cap;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        command   <= CMD_QUERY;
        position  <= '0;
        value     <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        issued     = 0;
        cfg_writes = 0;
        burst      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list refusals, boundary inserts, extremes, unknown codes
        issue(CMD_QUERY,      5'd0,  32'sd0);
        issue(CMD_FRONT,      5'd0,  32'sd0);
        issue(CMD_BACK,       5'd0,  32'sd0);
        issue(CMD_READ,       5'd0,  32'sd0);
        issue(CMD_WRITE,      5'd0,  32'sd5);
        issue(CMD_INSERT,     5'd1,  32'sd7);
        issue(CMD_INSERT,     5'd0,  32'h7fffffff);
        issue(CMD_PUSH_BACK,  5'd0,  32'h80000000);
        issue(CMD_PUSH_FRONT, 5'd31, -32'sd1);
        issue(CMD_INSERT,     5'd3,  32'h12345678);
        issue(CMD_INSERT,     5'd1,  32'h5a5a5a5a);
        issue(CMD_READ,       5'd3,  32'sd0);
        issue(CMD_READ,       5'd5,  32'sd0);
        issue(CMD_WRITE,      5'd4,  32'h0badcafe);
        issue(CMD_READ,       5'd4,  32'sd0);
        issue(CMD_FRONT,      5'd0,  32'sd0);
        issue(CMD_BACK,       5'd0,  32'sd0);
        issue(CMD_INSERT,     5'd31, 32'sd1);
        issue(CMD_READ,       5'd16, 32'sd0);
        issue(CMD_QUERY + 1'b1, 5'd0, 32'sd0);
        issue(CMD_TOP,        5'd0,  32'sd0);
        issue(CMD_CLEAR,      5'd0,  32'sd0);
        issue(CMD_BACK,       5'd0,  32'sd0);
        issue(CMD_QUERY,      5'd0,  32'sd0);

        // Random phases; the list is not cleared between them, so a lower
        // capacity often lands below the current count
        for (p = 0; p < 8; p++)
        begin
            cap = (p < 7) ? phase_caps[p] : CAP_W'($urandom_range(0, 31));
            write_capacity(cap);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 40 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                random_command();
            end
        end

        settle();
        $display("%0d commands issued, %0d carried out, %0d capacity writes",
                 issued, granted_count, cfg_writes);
        $display("capacity ran from zero to past the list depth; %0d mismatches", fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
